// ===== src/rgb2hsv_pkg.sv =====
package rgb2hsv_pkg;

   // default component width of the red, green and blue channels
   localparam int COMPONENT_BITS_DEFAULT = 8;

   // fixed result field widths
   localparam int ALPHA_W = 8;
   localparam int HUE_W   = 15;
   localparam int SAT_W   = 16;

   // both divider lanes deliver this many quotient bits, one per stage
   localparam int QUOT_W        = 16;
   // hue lane carries extra fraction bits below the hue unit
   localparam int HUE_FRAC_BITS = 4;
   // saturation numerator is delta scaled by 2^15
   localparam int SAT_SHIFT     = 15;
   // hue numerator 15*x is scaled by 2^8 (3840 = 15 * 256) and the fraction bits
   localparam int HUE_SHIFT     = QUOT_W - HUE_FRAC_BITS;

   // hue units of 1/64 degree
   localparam logic [HUE_W-1:0] HUE_SECTOR_UNIT = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_GREEN_BASE  = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_BLUE_BASE   = 15'd15360;
   localparam logic [HUE_W-1:0] FULL_TURN       = 15'd23040;
   localparam logic [SAT_W-1:0] SAT_ONE         = 16'd32768;

   // which component holds the maximum
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // hue control travelling alongside the divider
   typedef struct packed {
      sector_type sector;
      logic       neg;
      logic       achro;
   } hue_ctl_type;

endpackage

// ===== src/rgb_to_hsv_unit.sv =====
// stages: stage 1, stage 2, two 16-step restoring dividers, output register
// throughput: one request per cycle unless stalled; dividers do one step per stage
// the whole pipeline advances whenever the output register is empty or being taken
// reset clears every valid bit; data registers are not reset
module rgb_to_hsv_unit import rgb2hsv_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // red, green, blue, alpha_in from bit 0 up, zero padded to bytes
   input  logic [((3*COMPONENT_BITS+ALPHA_W+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // hue, saturation, value, alpha_out from bit 0 up, zero padded to bytes
   output logic [((HUE_W+SAT_W+COMPONENT_BITS+ALPHA_W+7)/8)*8-1:0] rsp_tdata,
   // achromatic
   output logic                 rsp_tuser
);

   localparam int C     = COMPONENT_BITS;
   localparam int RSP_W = ((HUE_W + SAT_W + C + ALPHA_W + 7) / 8) * 8;
   localparam int TAG_W = C + ALPHA_W;

   logic advance;

   // stage 1: max, min and sector
   logic [C-1:0]       red;
   logic [C-1:0]       green;
   logic [C-1:0]       blue;
   logic [ALPHA_W-1:0] alpha_in;
   logic [C-1:0]       mx_rg;
   logic [C-1:0]       mn_rg;
   logic [C-1:0]       mx_in;
   logic [C-1:0]       mn_in;
   logic [C-1:0]       pos_in;
   logic [C-1:0]       sub_in;
   sector_type         sector_in;

   logic               s1_valid_ff;
   logic [C-1:0]       s1_mx_ff;
   logic [C-1:0]       s1_mn_ff;
   logic [C-1:0]       s1_pos_ff;
   logic [C-1:0]       s1_sub_ff;
   sector_type         s1_sector_ff;
   logic [ALPHA_W-1:0] s1_alpha_ff;

   // stage 2: delta and signed difference
   logic [C-1:0]       delta_in;
   logic               neg_in;
   logic [C-1:0]       diff_mag;
   logic [C+3:0]       hue_num_in;

   logic               s2_valid_ff;
   logic [C-1:0]       s2_mx_ff;
   logic [C-1:0]       s2_delta_ff;
   logic [C+3:0]       s2_hue_num_ff;
   hue_ctl_type        s2_ctl_ff;
   logic [ALPHA_W-1:0] s2_alpha_ff;

   // divider outputs
   logic               div_valid;
   hue_ctl_type        div_ctl;
   logic [TAG_W-1:0]   div_tag;
   logic [QUOT_W-1:0]  sat_quot;
   logic [QUOT_W-1:0]  hue_quot;
   logic               hue_rem_nz;

   // output stage
   logic [HUE_W-1:0]   hue_whole;
   logic               hue_inexact;
   logic [HUE_W-1:0]   hue_base;
   logic [HUE_W-1:0]   hue_in;
   logic [SAT_W-1:0]   sat_in;

   logic               rsp_valid_ff;
   logic [HUE_W-1:0]   rsp_hue_ff;
   logic [SAT_W-1:0]   rsp_sat_ff;
   logic [C-1:0]       rsp_value_ff;
   logic [ALPHA_W-1:0] rsp_alpha_ff;
   logic               rsp_achro_ff;

   // pipeline moves when the output slot is free or being emptied
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // unpack the request
   assign red      = req_tdata[C-1:0];
   assign green    = req_tdata[2*C-1:C];
   assign blue     = req_tdata[3*C-1:2*C];
   assign alpha_in = req_tdata[3*C+ALPHA_W-1:3*C];

   // max, min, and the pair whose difference gives the hue offset
   always_comb begin
      mx_rg = (red > green) ? red : green;
      mn_rg = (red < green) ? red : green;
      mx_in = (mx_rg > blue) ? mx_rg : blue;
      mn_in = (mn_rg < blue) ? mn_rg : blue;
      if (red == mx_in) begin
         sector_in = SECTOR_RED;
         pos_in    = green;
         sub_in    = blue;
      end else if (green == mx_in) begin
         sector_in = SECTOR_GREEN;
         pos_in    = blue;
         sub_in    = red;
      end else begin
         sector_in = SECTOR_BLUE;
         pos_in    = red;
         sub_in    = green;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mx_ff     <= mx_in;
         s1_mn_ff     <= mn_in;
         s1_pos_ff    <= pos_in;
         s1_sub_ff    <= sub_in;
         s1_sector_ff <= sector_in;
         s1_alpha_ff  <= alpha_in;
      end
   end

   // delta, difference magnitude and sign; hue numerator is 15 times the magnitude
   always_comb begin
      delta_in   = s1_mx_ff - s1_mn_ff;
      neg_in     = (s1_pos_ff < s1_sub_ff);
      diff_mag   = neg_in ? (s1_sub_ff - s1_pos_ff) : (s1_pos_ff - s1_sub_ff);
      hue_num_in = ((C+4)'(diff_mag) << 4) - (C+4)'(diff_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mx_ff        <= s1_mx_ff;
         s2_delta_ff     <= delta_in;
         s2_hue_num_ff   <= hue_num_in;
         s2_ctl_ff       <= '{sector: s1_sector_ff, neg: neg_in, achro: (delta_in == '0)};
         s2_alpha_ff     <= s1_alpha_ff;
      end
   end

   // saturation and hue fraction dividers
   rgb2hsv_div_pipe #(
      .COMP_W (C),
      .TAG_W  (TAG_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s2_valid_ff),
      .in_ctl     (s2_ctl_ff),
      .in_tag     ({s2_alpha_ff, s2_mx_ff}),
      .sat_num    (s2_delta_ff),
      .sat_den    (s2_mx_ff),
      .hue_num    (s2_hue_num_ff),
      .hue_den    (s2_delta_ff),
      .out_valid  (div_valid),
      .out_ctl    (div_ctl),
      .out_tag    (div_tag),
      .sat_quot   (sat_quot),
      .hue_quot   (hue_quot),
      .hue_rem_nz (hue_rem_nz)
   );

   // sector base plus or minus the fraction; a negative fraction floors downwards
   always_comb begin
      hue_whole   = HUE_W'(hue_quot[QUOT_W-1:HUE_FRAC_BITS]);
      hue_inexact = (|hue_quot[HUE_FRAC_BITS-1:0]) || hue_rem_nz;
      case (div_ctl.sector)
         SECTOR_RED:   hue_base = div_ctl.neg ? FULL_TURN : '0;
         SECTOR_GREEN: hue_base = HUE_GREEN_BASE;
         SECTOR_BLUE:  hue_base = HUE_BLUE_BASE;
         default:      hue_base = '0;
      endcase
      if (div_ctl.achro) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = div_ctl.neg ? (hue_base - hue_whole - HUE_W'(hue_inexact))
                              : (hue_base + hue_whole);
         sat_in = sat_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hue_ff   <= hue_in;
         rsp_sat_ff   <= sat_in;
         rsp_value_ff <= div_tag[C-1:0];
         rsp_alpha_ff <= div_tag[TAG_W-1:C];
         rsp_achro_ff <= div_ctl.achro;
      end
   end

   // pack the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_alpha_ff, rsp_value_ff, rsp_sat_ff, rsp_hue_ff});
   assign rsp_tuser  = rsp_achro_ff;

   // grey pixels carry no hue and no saturation
   a_achro_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_achro_ff |-> (rsp_hue_ff == '0) && (rsp_sat_ff == '0))
      else $error("achromatic result with non-zero hue or saturation");

   // hue stays below a full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hue_ff < FULL_TURN))
      else $error("hue out of range");

   // saturation never exceeds one
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sat_ff <= SAT_ONE))
      else $error("saturation above one");

   // back-pressure only comes from a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff && !rsp_tready)
      else $error("request side stalled without a held result");

endmodule

// ===== src/rgb2hsv_div_pipe.sv =====
module rgb2hsv_div_pipe import rgb2hsv_pkg::*; #(
   parameter int COMP_W = COMPONENT_BITS_DEFAULT,
   parameter int TAG_W  = COMPONENT_BITS_DEFAULT + ALPHA_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  hue_ctl_type       in_ctl,
   input  logic [TAG_W-1:0]  in_tag,
   input  logic [COMP_W-1:0] sat_num,
   input  logic [COMP_W-1:0] sat_den,
   input  logic [COMP_W+3:0] hue_num,
   input  logic [COMP_W-1:0] hue_den,
   output logic              out_valid,
   output hue_ctl_type       out_ctl,
   output logic [TAG_W-1:0]  out_tag,
   output logic [QUOT_W-1:0] sat_quot,
   output logic [QUOT_W-1:0] hue_quot,
   output logic              hue_rem_nz
);

   localparam int REM_W = COMP_W + QUOT_W;
   localparam int LAST  = QUOT_W - 1;

   logic              valid_ff    [QUOT_W];
   hue_ctl_type       ctl_ff      [QUOT_W];
   logic [TAG_W-1:0]  tag_ff      [QUOT_W];
   logic [QUOT_W-1:0] sat_quot_ff [QUOT_W];
   logic [QUOT_W-1:0] hue_quot_ff [QUOT_W];
   logic [REM_W-1:0]  sat_rem_ff  [LAST];
   logic [REM_W-1:0]  hue_rem_ff  [LAST];
   logic [COMP_W-1:0] sat_den_ff  [LAST];
   logic [COMP_W-1:0] hue_den_ff  [LAST];
   logic              hue_nz_ff;

   // one restoring step per stage, both lanes side by side
   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int SHIFT = QUOT_W - 1 - k;

      logic              v_src;
      hue_ctl_type       ctl_src;
      logic [TAG_W-1:0]  tag_src;
      logic [REM_W-1:0]  sat_rem_src;
      logic [REM_W-1:0]  hue_rem_src;
      logic [COMP_W-1:0] sat_den_src;
      logic [COMP_W-1:0] hue_den_src;
      logic [QUOT_W-1:0] sat_q_src;
      logic [QUOT_W-1:0] hue_q_src;
      logic [REM_W-1:0]  sat_trial;
      logic [REM_W-1:0]  hue_trial;
      logic              sat_bit;
      logic              hue_bit;

      if (k == 0) begin : g_head
         // scaled numerators enter the first step
         assign v_src       = in_valid;
         assign ctl_src     = in_ctl;
         assign tag_src     = in_tag;
         assign sat_rem_src = REM_W'(sat_num) << SAT_SHIFT;
         assign hue_rem_src = REM_W'(hue_num) << HUE_SHIFT;
         assign sat_den_src = sat_den;
         assign hue_den_src = hue_den;
         assign sat_q_src   = '0;
         assign hue_q_src   = '0;
      end else begin : g_body
         assign v_src       = valid_ff[k-1];
         assign ctl_src     = ctl_ff[k-1];
         assign tag_src     = tag_ff[k-1];
         assign sat_rem_src = sat_rem_ff[k-1];
         assign hue_rem_src = hue_rem_ff[k-1];
         assign sat_den_src = sat_den_ff[k-1];
         assign hue_den_src = hue_den_ff[k-1];
         assign sat_q_src   = sat_quot_ff[k-1];
         assign hue_q_src   = hue_quot_ff[k-1];
      end

      // trial subtract against the shifted divisor
      always_comb begin
         sat_trial = REM_W'(sat_den_src) << SHIFT;
         hue_trial = REM_W'(hue_den_src) << SHIFT;
         sat_bit   = (sat_rem_src >= sat_trial);
         hue_bit   = (hue_rem_src >= hue_trial);
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= v_src;
         end
      end

      // stage payload
      always_ff @(posedge clock) begin
         if (advance) begin
            ctl_ff[k]      <= ctl_src;
            tag_ff[k]      <= tag_src;
            sat_quot_ff[k] <= {sat_q_src[QUOT_W-2:0], sat_bit};
            hue_quot_ff[k] <= {hue_q_src[QUOT_W-2:0], hue_bit};
         end
      end

      if (k < LAST) begin : g_rem
         logic [REM_W-1:0] sat_rem_in;
         logic [REM_W-1:0] hue_rem_in;

         always_comb begin
            sat_rem_in = sat_bit ? (sat_rem_src - sat_trial) : sat_rem_src;
            hue_rem_in = hue_bit ? (hue_rem_src - hue_trial) : hue_rem_src;
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               sat_rem_ff[k] <= sat_rem_in;
               hue_rem_ff[k] <= hue_rem_in;
               sat_den_ff[k] <= sat_den_src;
               hue_den_ff[k] <= hue_den_src;
            end
         end
      end else begin : g_tail
         logic [REM_W-1:0] hue_rem_in;

         // only the hue lane needs to know whether anything was left over
         always_comb begin
            hue_rem_in = hue_bit ? (hue_rem_src - hue_trial) : hue_rem_src;
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               hue_nz_ff <= |hue_rem_in;
            end
         end
      end
   end

   assign out_valid  = valid_ff[LAST];
   assign out_ctl    = ctl_ff[LAST];
   assign out_tag    = tag_ff[LAST];
   assign sat_quot   = sat_quot_ff[LAST];
   assign hue_quot   = hue_quot_ff[LAST];
   assign hue_rem_nz = hue_nz_ff;

endmodule
